### sv/md5_pkg.sv
// md5 package: payload types, constants, round tables
`timescale 1ns / 1ps
`default_nettype none
package md5_pkg;
  localparam int unsigned BlockBytes = 64;
  localparam int unsigned PadPos = 56;
  localparam logic [7:0] PadByte = 8'h80;
  localparam logic [31:0] Iv0 = 32'h67452301;
  localparam logic [31:0] Iv1 = 32'hefcdab89;
  localparam logic [31:0] Iv2 = 32'h98badcfe;
  localparam logic [31:0] Iv3 = 32'h10325476;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       has_byte;
    logic       is_last;
  } md5_in_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [1:0]  word_index;
    logic        last_word;
  } md5_out_t;

  function automatic logic [31:0] round_const(input logic [5:0] k);
    logic [31:0] r;
    unique case (k)
      6'd0: r = 32'hd76aa478; 6'd1: r = 32'he8c7b756; 6'd2: r = 32'h242070db;
      6'd3: r = 32'hc1bdceee; 6'd4: r = 32'hf57c0faf; 6'd5: r = 32'h4787c62a;
      6'd6: r = 32'ha8304613; 6'd7: r = 32'hfd469501; 6'd8: r = 32'h698098d8;
      6'd9: r = 32'h8b44f7af; 6'd10: r = 32'hffff5bb1; 6'd11: r = 32'h895cd7be;
      6'd12: r = 32'h6b901122; 6'd13: r = 32'hfd987193; 6'd14: r = 32'ha679438e;
      6'd15: r = 32'h49b40821; 6'd16: r = 32'hf61e2562; 6'd17: r = 32'hc040b340;
      6'd18: r = 32'h265e5a51; 6'd19: r = 32'he9b6c7aa; 6'd20: r = 32'hd62f105d;
      6'd21: r = 32'h02441453; 6'd22: r = 32'hd8a1e681; 6'd23: r = 32'he7d3fbc8;
      6'd24: r = 32'h21e1cde6; 6'd25: r = 32'hc33707d6; 6'd26: r = 32'hf4d50d87;
      6'd27: r = 32'h455a14ed; 6'd28: r = 32'ha9e3e905; 6'd29: r = 32'hfcefa3f8;
      6'd30: r = 32'h676f02d9; 6'd31: r = 32'h8d2a4c8a; 6'd32: r = 32'hfffa3942;
      6'd33: r = 32'h8771f681; 6'd34: r = 32'h6d9d6122; 6'd35: r = 32'hfde5380c;
      6'd36: r = 32'ha4beea44; 6'd37: r = 32'h4bdecfa9; 6'd38: r = 32'hf6bb4b60;
      6'd39: r = 32'hbebfbc70; 6'd40: r = 32'h289b7ec6; 6'd41: r = 32'heaa127fa;
      6'd42: r = 32'hd4ef3085; 6'd43: r = 32'h04881d05; 6'd44: r = 32'hd9d4d039;
      6'd45: r = 32'he6db99e5; 6'd46: r = 32'h1fa27cf8; 6'd47: r = 32'hc4ac5665;
      6'd48: r = 32'hf4292244; 6'd49: r = 32'h432aff97; 6'd50: r = 32'hab9423a7;
      6'd51: r = 32'hfc93a039; 6'd52: r = 32'h655b59c3; 6'd53: r = 32'h8f0ccc92;
      6'd54: r = 32'hffeff47d; 6'd55: r = 32'h85845dd1; 6'd56: r = 32'h6fa87e4f;
      6'd57: r = 32'hfe2ce6e0; 6'd58: r = 32'ha3014314; 6'd59: r = 32'h4e0811a1;
      6'd60: r = 32'hf7537e82; 6'd61: r = 32'hbd3af235; 6'd62: r = 32'h2ad7d2bb;
      default: r = 32'heb86d391;
    endcase
    return r;
  endfunction

  function automatic logic [4:0] rot_amount(input logic [5:0] k);
    logic [4:0] r;
    unique case ({k[5:4], k[1:0]})
      4'd0: r = 5'd7;  4'd1: r = 5'd12; 4'd2: r = 5'd17; 4'd3: r = 5'd22;
      4'd4: r = 5'd5;  4'd5: r = 5'd9;  4'd6: r = 5'd14; 4'd7: r = 5'd20;
      4'd8: r = 5'd4;  4'd9: r = 5'd11; 4'd10: r = 5'd16; 4'd11: r = 5'd23;
      4'd12: r = 5'd6; 4'd13: r = 5'd10; 4'd14: r = 5'd15; default: r = 5'd21;
    endcase
    return r;
  endfunction

  // message word index used by round k
  function automatic logic [3:0] word_sel(input logic [5:0] k);
    logic [3:0] g;
    unique case (k[5:4])
      2'd0: g = k[3:0];
      2'd1: g = 4'(k[3:0] * 4'd5 + 4'd1);
      2'd2: g = 4'(k[3:0] * 4'd3 + 4'd5);
      default: g = 4'(k[3:0] * 4'd7);
    endcase
    return g;
  endfunction
endpackage
`default_nettype wire

### sv/md5_round.sv
// md5 round unit: one compression round per cycle
`timescale 1ns / 1ps
`default_nettype none
module md5_round (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  input  wire logic [3:0][31:0]  chain_i,
  input  wire logic [31:0]       word_i,
  output logic [3:0]             word_addr_o,
  output logic                   done_o,
  output logic [3:0][31:0]       chain_o
);
  import md5_pkg::*;

  logic        busy_q, busy_d;
  logic [5:0]  k_q, k_d;
  logic [31:0] a_q, b_q, c_q, d_q;
  logic [31:0] f, t, rot;

  assign word_addr_o = word_sel(k_q);

  always_comb begin
    unique case (k_q[5:4])
      2'd0: f = (b_q & c_q) | (~b_q & d_q);
      2'd1: f = (b_q & d_q) | (c_q & ~d_q);
      2'd2: f = b_q ^ c_q ^ d_q;
      default: f = c_q ^ (b_q | ~d_q);
    endcase
    t = a_q + f + word_i + round_const(k_q);
    rot = (t << rot_amount(k_q)) | (t >> (6'd32 - {1'b0, rot_amount(k_q)}));
  end

  always_comb begin
    busy_d = busy_q;
    k_d = k_q;
    done_o = 1'b0;
    if (start_i) begin
      busy_d = 1'b1;
      k_d = '0;
    end else if (busy_q) begin
      k_d = k_q + 6'd1;
      if (k_q == 6'd63) begin
        busy_d = 1'b0;
        done_o = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      k_q <= '0;
    end else begin
      busy_q <= busy_d;
      k_q <= k_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q <= chain_i[0];
      b_q <= chain_i[1];
      c_q <= chain_i[2];
      d_q <= chain_i[3];
    end else if (busy_q) begin
      a_q <= d_q;
      d_q <= c_q;
      c_q <= b_q;
      b_q <= b_q + rot;
    end
  end

  // final round result, valid alongside done_o
  assign chain_o[0] = d_q;
  assign chain_o[1] = b_q + rot;
  assign chain_o[2] = b_q;
  assign chain_o[3] = c_q;
endmodule
`default_nettype wire

### sv/md5_stream_hasher.sv
// md5 stream hasher top level: byte collection, padding sequencer, digest output
//
// usage: one byte per input transaction on in_*; has_byte=0 with is_last=1
// finishes the message (alone it gives the empty-message digest).
// a byte that does not fill the block leaves in_ready_o high. a byte that
// fills the block starts a compression in the shared round unit, one round
// per cycle: in_ready_o stays low until the rounds finish.
// a last transaction feeds 0x80, zero padding and the 64-bit bit count one
// byte per cycle through the same path, compressing one or two blocks; the
// first digest word is valid once the rounds of the last block finish.
// the digest then leaves as four out transactions, word 0 first,
// last_word set on word 3. a stalled receiver holds the word on the output
// from the chaining registers; input stays blocked until word 3 is taken
// and through the done state, in which the state returns to its initial values.
// sustained rate is set by the round loop: input is blocked while a block compresses.
// reset loads the standard chaining values and clears count and position;
// the block buffer needs no clearing since each entry is written before use.
`timescale 1ns / 1ps
`default_nettype none
module md5_stream_hasher (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire md5_pkg::md5_in_t in_data_i,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  output md5_pkg::md5_out_t     out_data_o
);
  import md5_pkg::*;

  typedef enum logic [4:0] {
    StIdle = 5'b00001,
    StPad  = 5'b00010,
    StComp = 5'b00100,
    StOut  = 5'b01000,
    StDone = 5'b10000
  } state_e;

  state_e state_q, state_d;
  logic [3:0][31:0] chain_q;
  logic [63:0] bit_len_q;
  logic [5:0]  pos_q;
  logic        fin_q;       // finishing a message
  logic        two_blk_q;   // marker landed in the length field, length goes next block
  logic [63:0] len_lat_q;   // length latched at finish
  logic [1:0]  out_idx_q;
  logic [31:0] buf_mem [BlockBytes / 4];
  logic [31:0] word_rd;
  logic [3:0]  word_addr;
  logic        rnd_done, rnd_start;
  logic [3:0][31:0] rnd_chain;
  logic        wr_en;
  logic [7:0]  wr_byte;
  logic [31:0] out_word;

  // byte source during padding
  logic [7:0] pad_byte;
  logic       in_fire;
  always_comb begin
    if (pos_q >= 6'(PadPos) && !two_blk_q) begin
      pad_byte = len_lat_q[{pos_q[2:0], 3'b000} +: 8];
    end else begin
      pad_byte = 8'h00;
    end
  end

  assign in_ready_o = (state_q == StIdle);
  assign in_fire = in_valid_i && in_ready_o;

  logic pad_first_q;  // next pad byte is the 0x80 marker

  always_comb begin
    wr_en = 1'b0;
    wr_byte = in_data_i.data_byte;
    if (in_fire && in_data_i.has_byte) begin
      wr_en = 1'b1;
    end else if (state_q == StPad) begin
      wr_en = 1'b1;
      wr_byte = pad_first_q ? PadByte : pad_byte;
    end
  end

  // word read: the round unit addresses the block combinationally per round
  assign word_rd = buf_mem[word_addr];

  // bytes land little-endian in the sixteen block words
  always_ff @(posedge clk_i) begin
    if (wr_en) buf_mem[pos_q[5:2]][{pos_q[1:0], 3'b000} +: 8] <= wr_byte;
  end

  assign rnd_start = wr_en && (pos_q == 6'd63);

  md5_round u_round (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (rnd_start),
    .chain_i    (chain_q),
    .word_i     (word_rd),
    .word_addr_o(word_addr),
    .done_o     (rnd_done),
    .chain_o    (rnd_chain)
  );

  logic pad_end;
  assign pad_end = pos_q == 6'd63;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: begin
        if (in_fire) begin
          if (in_data_i.has_byte && pos_q == 6'd63) state_d = StComp;
          else if (in_data_i.is_last) state_d = StPad;
        end
      end
      StPad:  if (pad_end) state_d = StComp;
      StComp: begin
        if (rnd_done) begin
          if (!fin_q) state_d = StIdle;
          else if (len_lat_q != bit_len_q || pad_first_q) state_d = StPad;
          else state_d = StOut;
        end
      end
      StOut:  if (out_ready_i && out_idx_q == 2'd3) state_d = StDone;
      StDone: state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      chain_q <= {Iv3, Iv2, Iv1, Iv0};
      bit_len_q <= '0;
      pos_q <= '0;
      fin_q <= 1'b0;
      two_blk_q <= 1'b0;
      pad_first_q <= 1'b0;
      len_lat_q <= '0;
      out_idx_q <= '0;
    end else begin
      state_q <= state_d;
      if (wr_en) pos_q <= pos_q + 6'd1;
      if (in_fire && in_data_i.is_last) begin
        fin_q <= 1'b1;
        pad_first_q <= 1'b1;
        len_lat_q <= bit_len_q + (in_data_i.has_byte ? 64'd8 : 64'd0);
        // bit_len_q doubles as a marker: inverted length until the length bytes go
        bit_len_q <= ~(bit_len_q + (in_data_i.has_byte ? 64'd8 : 64'd0));
      end else if (in_fire && in_data_i.has_byte) begin
        bit_len_q <= bit_len_q + 64'd8;
      end
      if (state_q == StPad) begin
        pad_first_q <= 1'b0;
        if (pos_q == 6'd63) two_blk_q <= 1'b0;
        else if (pad_first_q && pos_q >= 6'(PadPos)) two_blk_q <= 1'b1;
        if (pos_q == 6'd63 && !pad_first_q && !two_blk_q) bit_len_q <= len_lat_q;
      end
      if (rnd_done) chain_q <= {chain_q[3] + rnd_chain[3], chain_q[2] + rnd_chain[2],
                               chain_q[1] + rnd_chain[1], chain_q[0] + rnd_chain[0]};
      if (state_q == StOut && out_ready_i) out_idx_q <= out_idx_q + 2'd1;
      if (state_q == StDone) begin
        chain_q <= {Iv3, Iv2, Iv1, Iv0};
        bit_len_q <= '0;
        pos_q <= '0;
        fin_q <= 1'b0;
        out_idx_q <= '0;
      end
    end
  end

  always_comb out_word = chain_q[out_idx_q];

  assign out_valid_o = (state_q == StOut);
  assign out_data_o.digest_word = out_word;
  assign out_data_o.word_index = out_idx_q;
  assign out_data_o.last_word = (out_idx_q == 2'd3);

  // no input transaction while the round unit runs
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StComp |-> !in_ready_o) else $error("input taken during compression");
  // a compression only completes from the compress state
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rnd_done |-> state_q == StComp) else $error("stray round completion");
  // output word index holds while the output is stalled
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StOut && !out_ready_i) |=> $stable(out_idx_q))
    else $error("digest index moved while stalled");
endmodule
`default_nettype wire
